// File: hw/rtl/uniform_grid_point_binning_macros.svh
// Assertion macros for the uniform grid point binning block.
// Used by the top level only; expects clk and rst_n in scope.
`ifndef UNIFORM_GRID_POINT_BINNING_MACROS_SVH
`define UNIFORM_GRID_POINT_BINNING_MACROS_SVH

// Condition that must hold at every clock edge out of reset
`define UGPB_ASSERT(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("ugpb invariant violated");

// Antecedent in one cycle implies consequent in the next
`define UGPB_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ugpb sequence violated");

`endif

// File: hw/rtl/ugpb_pkg.sv
// Shared constants, codes and types for the uniform grid point binning block.
// No dependencies; imported by ugpb_lane and the top level.
package ugpb_pkg;

  localparam int COORD_BITS = 24;
  localparam int AXIS_BITS  = 4;
  localparam int GRID_AXIS  = 1 << AXIS_BITS;
  localparam int AXIS_W     = AXIS_BITS + 1;
  localparam int MAX_POINTS = 1024;
  localparam int PT_AW      = $clog2(MAX_POINTS);
  localparam int PT_CNT_W   = PT_AW + 1;
  localparam int CNT_AW     = 3 * AXIS_BITS;
  localparam int CNT_W      = 11;
  localparam int CELL_SAT   = (1 << CNT_W) - 1;
  localparam int DIV_W      = COORD_BITS + AXIS_BITS;
  localparam int K_W        = $clog2(AXIS_BITS + 1);
  localparam int IN_TDATA_W  = 88;
  localparam int OUT_TDATA_W = 104;
  localparam int CFG_W      = 24;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_OVERFLOW  = 2'd1;
  localparam logic [1:0] ST_RANGE     = 2'd2;
  localparam logic [1:0] ST_NOT_READY = 2'd3;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_READ = 1'b1;

  localparam logic CFG_CELL_SIZE = 1'b0;
  localparam logic CFG_DIMS      = 1'b1;

  localparam logic [1:0] DIMS_2D = 2'd2;

  typedef struct packed {
    logic                 done;
    logic                 big;
    logic [AXIS_BITS-1:0] quo;
  } lane_out_t;

  typedef struct packed {
    logic [1:0]            status;
    logic [AXIS_W-1:0]     grid_x;
    logic [AXIS_W-1:0]     grid_y;
    logic [AXIS_W-1:0]     grid_z;
    logic [COORD_BITS-1:0] min_x;
    logic [COORD_BITS-1:0] min_y;
    logic [COORD_BITS-1:0] min_z;
    logic [CNT_W-1:0]      cell_count;
  } res_t;

endpackage

// File: hw/rtl/ugpb_lane.sv
// One axis lane: restoring divider yielding a cell index and a flag for the grid edge.
// Depends on ugpb_pkg.
module ugpb_lane (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [ugpb_pkg::COORD_BITS-1:0] dividend,
  input  logic [ugpb_pkg::COORD_BITS-1:0] divisor,
  output ugpb_pkg::lane_out_t            res
);
  import ugpb_pkg::*;

  logic                  busy_r;
  logic                  done_r;
  logic [K_W-1:0]        k_r;
  logic [DIV_W-1:0]      rem_r;
  logic [COORD_BITS-1:0] dvs_r;
  logic [AXIS_BITS:0]    quo_r;
  logic [DIV_W-1:0]      trial;
  logic                  fits;

  // top quotient bit set means the index is at or beyond the grid edge
  assign trial = DIV_W'(dvs_r) << k_r;
  assign fits  = rem_r >= trial;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      k_r    <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        k_r    <= K_W'(AXIS_BITS);
        rem_r  <= DIV_W'(dividend);
        dvs_r  <= divisor;
        quo_r  <= '0;
      end else if (busy_r) begin
        if (fits) rem_r <= rem_r - trial;
        quo_r <= {quo_r[AXIS_BITS-1:0], fits};
        if (k_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          k_r <= k_r - K_W'(1);
        end
      end
    end
  end

  assign res.done = done_r;
  assign res.big  = quo_r[AXIS_BITS];
  assign res.quo  = quo_r[AXIS_BITS-1:0];

endmodule

// File: hw/rtl/uniform_grid_point_binning.sv
// Top level of the uniform grid point binning block: control, point and count memories.
// Depends on ugpb_pkg, ugpb_lane and uniform_grid_point_binning_macros.svh.
//
// Usage: requests enter on in_* (tuser = opcode, tlast = last point), results leave
// on out_*, one per request. cell_size and dimensions are set through cfg_*.
// A load without tlast registers its result in the cycle after acceptance; a read first
// registers its status and the count memory word, then its result. A load does not
// hold off the next request; a read does until its result is registered.
// A load with tlast starts binning: three lanes divide per axis in parallel for the
// grid, then a clearing pass runs over all 4096 words of the count memory, then each
// stored point takes a point read, a 5-step divide and a count read-modify-write.
// The binning result follows the last point.
// in_tready is low while a request is in work or its result cannot be registered;
// a stalled out_tready holds the result and blocks new requests.
// Reset (rst_n low, synchronous) empties the point set, marks no grid ready, sets
// grid sizes to one, origin to zero, cell_size to 256 and dimensions to 3.
`include "uniform_grid_point_binning_macros.svh"
module uniform_grid_point_binning (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic                             cfg_index,
  input  logic [ugpb_pkg::CFG_W-1:0]       cfg_data,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // coord_x, coord_y, coord_z, cell_x, cell_y, cell_z, zero pad
  input  logic [ugpb_pkg::IN_TDATA_W-1:0]  in_tdata,
  // opcode
  input  logic [0:0]                       in_tuser,
  input  logic                             in_tlast,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // status, grid_x, grid_y, grid_z, min_x, min_y, min_z, cell_count, zero pad
  output logic [ugpb_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import ugpb_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_RDWAIT, S_GRID_GO, S_GRID_WAIT, S_CLR,
    S_PT_ADDR, S_PT_DATA, S_PT_DIV, S_CNT_RD, S_CNT_WAIT, S_DONE
  } state_t;

  state_t state_r;

  logic [COORD_BITS-1:0] cell_size_r;
  logic [1:0]            dims_r;
  logic                  set_open_r, ovf_r, grid_ready_r;
  logic [PT_CNT_W-1:0]   total_r, p_r;
  logic signed [COORD_BITS-1:0] lo_r [3];
  logic signed [COORD_BITS-1:0] hi_r [3];
  logic signed [COORD_BITS-1:0] origin_r [3];
  logic [AXIS_W-1:0]     cells_r [3];
  logic [CNT_AW-1:0]     clr_idx_r, bin_lin_r;
  logic [1:0]            rd_status_r;
  logic                  out_valid_r;
  res_t                  out_r;

  logic [3*COORD_BITS-1:0] pt_mem [MAX_POINTS];
  logic [3*COORD_BITS-1:0] pt_q;
  logic [CNT_W-1:0]        cnt_mem [1 << CNT_AW];
  logic [CNT_W-1:0]        cnt_q;

  logic                  in_acc, flat;
  logic                  op;
  logic signed [COORD_BITS-1:0] in_c [3];
  logic [AXIS_BITS-1:0]  in_cell [3];
  logic [CNT_AW-1:0]     in_lin, cnt_raddr;
  logic                  ld_store, ld_ovf;
  logic [PT_CNT_W-1:0]   ld_tot_base, ld_tot;
  logic signed [COORD_BITS-1:0] ld_lo [3];
  logic signed [COORD_BITS-1:0] ld_hi [3];
  logic [1:0]            rd_status;
  logic [COORD_BITS-1:0] step;
  logic                  lane_start;
  logic [COORD_BITS-1:0] lane_dvd [3];
  lane_out_t             lane_o [3];
  logic [AXIS_W-1:0]     grid_n [3];
  logic                  grid_big;
  logic [AXIS_BITS-1:0]  bin_idx [3];
  logic [CNT_W-1:0]      cnt_inc;
  logic                  cnt_we;
  logic [CNT_AW-1:0]     cnt_waddr;
  logic [CNT_W-1:0]      cnt_wdata;
  logic                  pt_we;
  logic                  out_set;

  assign in_tready = (state_r == S_IDLE) && (!out_valid_r || out_tready);
  assign in_acc    = in_tvalid && in_tready;
  assign op        = in_tuser[0];
  assign flat      = dims_r == DIMS_2D;
  assign step      = (cell_size_r == '0) ? COORD_BITS'(1) : cell_size_r;

  assign in_c[0]    = in_tdata[23:0];
  assign in_c[1]    = in_tdata[47:24];
  assign in_c[2]    = in_tdata[71:48];
  assign in_cell[0] = in_tdata[75:72];
  assign in_cell[1] = in_tdata[79:76];
  assign in_cell[2] = in_tdata[83:80];
  assign in_lin     = {in_cell[0], in_cell[1], in_cell[2]};

  // load bookkeeping: the first load of a set seeds the corners
  always_comb begin
    ld_tot_base = set_open_r ? total_r : '0;
    ld_store    = ld_tot_base < PT_CNT_W'(MAX_POINTS);
    ld_tot      = ld_store ? ld_tot_base + PT_CNT_W'(1) : ld_tot_base;
    ld_ovf      = (set_open_r && ovf_r) || !ld_store;
    for (int a = 0; a < 3; a++) begin
      ld_lo[a] = set_open_r ? lo_r[a] : in_c[a];
      ld_hi[a] = set_open_r ? hi_r[a] : in_c[a];
      if (ld_store && in_c[a] < ld_lo[a]) ld_lo[a] = in_c[a];
      if (ld_store && in_c[a] > ld_hi[a]) ld_hi[a] = in_c[a];
    end
  end

  always_comb begin
    if (!grid_ready_r) begin
      rd_status = ST_NOT_READY;
    end else if ({1'b0, in_cell[0]} >= cells_r[0] || {1'b0, in_cell[1]} >= cells_r[1] ||
                 {1'b0, in_cell[2]} >= cells_r[2]) begin
      rd_status = ST_RANGE;
    end else begin
      rd_status = ST_OK;
    end
  end

  // lane operands: grid extent, or point offset from the origin
  assign lane_start = (state_r == S_GRID_GO) || (state_r == S_PT_DATA);
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      if (flat && a == 2) begin
        lane_dvd[a] = '0;
      end else if (state_r == S_GRID_GO) begin
        lane_dvd[a] = COORD_BITS'(hi_r[a] - lo_r[a]);
      end else begin
        lane_dvd[a] = COORD_BITS'(pt_q[a*COORD_BITS +: COORD_BITS] - origin_r[a]);
      end
    end
  end

  for (genvar g = 0; g < 3; g++) begin : g_lane
    ugpb_lane u_lane (
      .clk      (clk),
      .rst_n    (rst_n),
      .start    (lane_start),
      .dividend (lane_dvd[g]),
      .divisor  (step),
      .res      (lane_o[g])
    );
  end

  // merge: grid sizes, clamped cell indices
  always_comb begin
    grid_big = 1'b0;
    for (int a = 0; a < 3; a++) begin
      grid_n[a] = lane_o[a].big ? AXIS_W'(GRID_AXIS) : {1'b0, lane_o[a].quo} + AXIS_W'(1);
      grid_big  = grid_big || lane_o[a].big;
      bin_idx[a] = lane_o[a].big ? AXIS_BITS'(GRID_AXIS - 1) : lane_o[a].quo;
      if ({1'b0, bin_idx[a]} >= cells_r[a]) bin_idx[a] = AXIS_BITS'(cells_r[a] - AXIS_W'(1));
    end
  end

  assign cnt_inc   = (cnt_q == CNT_W'(CELL_SAT)) ? cnt_q : cnt_q + CNT_W'(1);
  assign cnt_raddr = (state_r == S_IDLE) ? in_lin : bin_lin_r;
  assign cnt_we    = (state_r == S_CLR) || (state_r == S_CNT_WAIT);
  assign cnt_waddr = (state_r == S_CLR) ? clr_idx_r : bin_lin_r;
  assign cnt_wdata = (state_r == S_CLR) ? '0 : cnt_inc;
  assign pt_we     = in_acc && op == OP_LOAD && ld_store;

  // a result is registered for a plain load, a read, or the end of binning
  assign out_set = ((state_r == S_IDLE) && in_acc && op == OP_LOAD && !in_tlast) ||
                   (state_r == S_RDWAIT) || (state_r == S_DONE);

  always_ff @(posedge clk) begin
    if (pt_we) pt_mem[ld_tot_base[PT_AW-1:0]] <= {in_c[2], in_c[1], in_c[0]};
    pt_q <= pt_mem[p_r[PT_AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (cnt_we) cnt_mem[cnt_waddr] <= cnt_wdata;
    cnt_q <= cnt_mem[cnt_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      cell_size_r  <= COORD_BITS'(256);
      dims_r       <= 2'd3;
      set_open_r   <= 1'b0;
      ovf_r        <= 1'b0;
      grid_ready_r <= 1'b0;
      total_r      <= '0;
      p_r          <= '0;
      out_valid_r  <= 1'b0;
      for (int a = 0; a < 3; a++) begin
        lo_r[a]     <= '0;
        hi_r[a]     <= '0;
        origin_r[a] <= '0;
        cells_r[a]  <= AXIS_W'(1);
      end
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_CELL_SIZE: cell_size_r <= cfg_data[COORD_BITS-1:0];
          CFG_DIMS:      dims_r      <= cfg_data[1:0];
        endcase
      end
      out_valid_r <= out_set || (out_valid_r && !out_tready);

      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            if (op == OP_LOAD) begin
              set_open_r <= 1'b1;
              ovf_r      <= ld_ovf;
              total_r    <= ld_tot;
              for (int a = 0; a < 3; a++) begin
                lo_r[a] <= ld_lo[a];
                hi_r[a] <= ld_hi[a];
              end
              if (in_tlast) begin
                state_r <= S_GRID_GO;
              end else begin
                out_r.status     <= ld_ovf ? ST_OVERFLOW : ST_OK;
                out_r.grid_x     <= cells_r[0];
                out_r.grid_y     <= cells_r[1];
                out_r.grid_z     <= cells_r[2];
                out_r.min_x      <= origin_r[0];
                out_r.min_y      <= origin_r[1];
                out_r.min_z      <= origin_r[2];
                out_r.cell_count <= '0;
              end
            end else begin
              rd_status_r <= rd_status;
              state_r     <= S_RDWAIT;
            end
          end
        end
        S_RDWAIT: begin
          out_r.status     <= rd_status_r;
          out_r.grid_x     <= cells_r[0];
          out_r.grid_y     <= cells_r[1];
          out_r.grid_z     <= cells_r[2];
          out_r.min_x      <= origin_r[0];
          out_r.min_y      <= origin_r[1];
          out_r.min_z      <= origin_r[2];
          out_r.cell_count <= (rd_status_r == ST_OK) ? cnt_q : '0;
          state_r          <= S_IDLE;
        end
        S_GRID_GO: state_r <= S_GRID_WAIT;
        S_GRID_WAIT: begin
          if (lane_o[0].done) begin
            for (int a = 0; a < 3; a++) begin
              cells_r[a]  <= grid_n[a];
              origin_r[a] <= (flat && a == 2) ? '0 : lo_r[a];
            end
            if (grid_big) ovf_r <= 1'b1;
            clr_idx_r <= '0;
            state_r   <= S_CLR;
          end
        end
        S_CLR: begin
          clr_idx_r <= clr_idx_r + CNT_AW'(1);
          if (clr_idx_r == '1) begin
            p_r     <= '0;
            state_r <= S_PT_ADDR;
          end
        end
        S_PT_ADDR: state_r <= (p_r == total_r) ? S_DONE : S_PT_DATA;
        S_PT_DATA: state_r <= S_PT_DIV;
        S_PT_DIV: begin
          if (lane_o[0].done) begin
            bin_lin_r <= {bin_idx[0], bin_idx[1], bin_idx[2]};
            state_r   <= S_CNT_RD;
          end
        end
        S_CNT_RD: state_r <= S_CNT_WAIT;
        S_CNT_WAIT: begin
          p_r     <= p_r + PT_CNT_W'(1);
          state_r <= S_PT_ADDR;
        end
        S_DONE: begin
          grid_ready_r     <= 1'b1;
          total_r          <= '0;
          set_open_r       <= 1'b0;
          out_r.status     <= ovf_r ? ST_OVERFLOW : ST_OK;
          out_r.grid_x     <= cells_r[0];
          out_r.grid_y     <= cells_r[1];
          out_r.grid_z     <= cells_r[2];
          out_r.min_x      <= origin_r[0];
          out_r.min_y      <= origin_r[1];
          out_r.min_z      <= origin_r[2];
          out_r.cell_count <= '0;
          state_r          <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0, out_r.cell_count, out_r.min_z, out_r.min_y, out_r.min_x,
                       out_r.grid_z, out_r.grid_y, out_r.grid_x, out_r.status};

  `UGPB_ASSERT(a_total_bound, total_r <= PT_CNT_W'(MAX_POINTS))
  `UGPB_ASSERT(a_lanes_agree, lane_o[0].done == lane_o[1].done && lane_o[1].done == lane_o[2].done)
  `UGPB_ASSERT(a_cells_range, cells_r[0] != '0 && cells_r[1] != '0 && cells_r[2] != '0 && cells_r[0] <= AXIS_W'(GRID_AXIS) && cells_r[1] <= AXIS_W'(GRID_AXIS) && cells_r[2] <= AXIS_W'(GRID_AXIS))
  `UGPB_ASSERT_NEXT(a_bin_result, state_r == S_DONE, out_valid_r && grid_ready_r && !set_open_r)

endmodule
